### src/cell_heat_colorizer_defines.svh
// Assertion macros shared by the checker files of the colorizer.
`ifndef CELL_HEAT_COLORIZER_DEFINES_SVH
`define CELL_HEAT_COLORIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define CHC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("colorizer check failed");

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define CHC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("colorizer check failed");

`endif

### src/chc_pkg.sv
package chc_pkg;

	// Material codes of cell_type; codes 8 to 15 are invalid.
	localparam logic [3:0] MAT_EMPTY = 4'd0;
	localparam logic [3:0] MAT_WALL  = 4'd1;
	localparam logic [3:0] MAT_SAND  = 4'd2;
	localparam logic [3:0] MAT_WATER = 4'd3;
	localparam logic [3:0] MAT_OIL   = 4'd4;
	localparam logic [3:0] MAT_FIRE  = 4'd5;
	localparam logic [3:0] MAT_SMOKE = 4'd6;
	localparam logic [3:0] MAT_LAVA  = 4'd7;

	// Register stages from the input transfer to the output register.
	localparam int STAGES = 5;

	// ceil(2^20 / 127): exact quotient for dividends below 16644.
	localparam logic [13:0] RECIP127 = 14'd8257;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic       is_lava;
		logic [3:0] cell_type;
		logic [5:0] heat;      // 0..60
		logic [5:0] mob;       // 0..40
		logic [2:0] strength;  // 0..4
		logic [7:0] fold_ph;
		logic [7:0] pulse_ph;
	} front_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} lava_en_t;

	// v / 3 for v below 128.
	function automatic logic [5:0] div3_7(input logic [6:0] v);
		logic [13:0] p;
		p = {7'b0, v} * 14'd43;
		return p[12:7];
	endfunction

	// v / 10 for v below 128.
	function automatic logic [3:0] div10_7(input logic [6:0] v);
		logic [14:0] p;
		p = {8'b0, v} * 15'd205;
		return p[14:11];
	endfunction

	// v / 6 for v below 64.
	function automatic logic [3:0] div6_6(input logic [5:0] v);
		logic [11:0] p;
		p = {6'b0, v} * 12'd43;
		return p[11:8];
	endfunction

	function automatic logic [7:0] sat8(input logic [8:0] v);
		return v[8] ? 8'hFF : v[7:0];
	endfunction

endpackage

### src/chc_cell_if.sv
interface chc_cell_if #(parameter int COORD_BITS = 12) ();
	logic                  valid;
	logic                  ready;
	logic [3:0]            cell_type;
	logic signed [15:0]    temperature;
	logic signed [7:0]     flow_direction;
	logic [7:0]            flow_level;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [15:0]           frame_tick;

	modport source (
		output valid, cell_type, temperature, flow_direction, flow_level,
		output pos_x, pos_y, frame_tick,
		input  ready
	);
	modport sink (
		input  valid, cell_type, temperature, flow_direction, flow_level,
		input  pos_x, pos_y, frame_tick,
		output ready
	);
endinterface

### src/chc_pixel_if.sv
interface chc_pixel_if ();
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

### src/chc_front.sv
module chc_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [3:0]            cell_type,
	input  logic signed [15:0]    temperature,
	input  logic signed [7:0]     flow_direction,
	input  logic [7:0]            flow_level,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [15:0]           frame_tick,
	output chc_pkg::front_t       front_s1
);

	localparam logic [7:0] BIAS_ZERO = 8'd2;
	localparam logic [7:0] BIAS_POS  = 8'd5;
	localparam logic [7:0] BIAS_NEG  = 8'd251;  // -5 modulo 256

	logic [16:0] heat_off;
	logic [16:0] mob_off;
	logic [21:0] mob_prod;
	logic [7:0]  bias;
	logic [7:0]  t8;
	logic [7:0]  x8;
	logic [7:0]  y8;
	logic [7:0]  dir8;
	logic [7:0]  s8;
	chc_pkg::front_t front_d;

	assign t8   = frame_tick[7:0];
	assign x8   = pos_x[7:0];
	assign y8   = pos_y[7:0];
	assign dir8 = flow_direction;

	// Offsets are taken in 17 bits so the sign bit shows a value below zero.
	assign heat_off = {temperature[15], temperature} - 17'd20;
	assign mob_off  = {temperature[15], temperature} - 17'd180;
	assign mob_prod = {12'b0, mob_off[9:0]} * 22'd3641;

	always_comb begin
		front_d.is_lava   = (cell_type == chc_pkg::MAT_LAVA);
		front_d.cell_type = cell_type;

		if (heat_off[16] || heat_off == '0) begin
			front_d.heat = 6'd0;
		end else if (heat_off >= 17'd240) begin
			front_d.heat = 6'd60;
		end else begin
			front_d.heat = heat_off[7:2];
		end

		// Division by 18 through its reciprocal, exact below 720.
		if (mob_off[16] || mob_off == '0) begin
			front_d.mob = 6'd0;
		end else if (mob_off >= 17'd720) begin
			front_d.mob = 6'd40;
		end else begin
			front_d.mob = mob_prod[21:16];
		end

		front_d.strength = (flow_level > 8'd4) ? 3'd4 : flow_level[2:0];
		s8 = {5'b0, front_d.strength};

		if (dir8 == '0) begin
			bias = BIAS_ZERO;
		end else if (dir8[7]) begin
			bias = BIAS_NEG;
		end else begin
			bias = BIAS_POS;
		end

		// Only the low eight bits of either phase reach the waves.
		front_d.fold_ph  = t8 * 8'd3 + bias * x8 + y8 * 8'd7 + s8 * 8'd13;
		front_d.pulse_ph = (s8 + 8'd4) * t8 + x8 * 8'd17 - y8 * 8'd11 + dir8 * 8'd19;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			front_s1 <= front_d;
		end
	end

endmodule

### src/chc_tint.sv
module chc_tint (
	input  logic [3:0]    cell_type,
	input  logic [5:0]    heat,
	output chc_pkg::rgb_t rgb
);

	logic [6:0] heat2;
	logic [6:0] glow_sand;
	logic [5:0] glow_water;
	logic [6:0] glow_oil;
	logic [8:0] oil_g3;
	logic [5:0] glow_smoke;

	assign heat2      = {heat, 1'b0};
	assign glow_sand  = (heat2 > 7'd100) ? 7'd100 : heat2;
	assign glow_water = (heat > 6'd48) ? 6'd48 : heat;
	assign glow_oil   = (heat2 > 7'd110) ? 7'd110 : heat2;
	assign oil_g3     = {2'b0, glow_oil} * 9'd3;
	assign glow_smoke = (heat > 6'd55) ? 6'd55 : heat;

	// Channel sums wrap to eight bits.
	always_comb begin
		unique case (cell_type)
			chc_pkg::MAT_EMPTY: begin
				rgb = '0;
			end
			chc_pkg::MAT_WALL: begin
				rgb.red   = 8'd100 + {2'b0, heat};
				rgb.green = 8'd100 + {3'b0, heat[5:1]};
				rgb.blue  = 8'd110 - {2'b0, chc_pkg::div3_7({1'b0, heat})};
			end
			chc_pkg::MAT_SAND: begin
				rgb.red   = 8'd210 + {2'b0, chc_pkg::div3_7(glow_sand)};
				rgb.green = 8'd185 + {4'b0, chc_pkg::div10_7(glow_sand)};
				// Never falls below its floor of 35, so no clamp is needed.
				rgb.blue  = 8'd85 - {2'b0, glow_sand[6:1]};
			end
			chc_pkg::MAT_WATER: begin
				rgb.red   = 8'd70 + {2'b0, chc_pkg::div3_7({1'b0, glow_water})};
				rgb.green = 8'd125 + {3'b0, glow_water[5:1]};
				rgb.blue  = 8'd235 - {4'b0, glow_water[5:2]};
			end
			chc_pkg::MAT_OIL: begin
				rgb.red   = 8'd35 + {1'b0, glow_oil};
				rgb.green = 8'd35 + {1'b0, oil_g3[8:2]};
				rgb.blue  = 8'd45 + {3'b0, glow_oil[6:2]};
			end
			chc_pkg::MAT_FIRE: begin
				rgb.red   = 8'd220 + {3'b0, heat[5:1]};
				rgb.green = 8'd90 + {2'b0, heat};
				rgb.blue  = 8'd25;
			end
			chc_pkg::MAT_SMOKE: begin
				rgb.red   = 8'd140 + {2'b0, glow_smoke};
				rgb.green = 8'd140 + {2'b0, glow_smoke};
				rgb.blue  = 8'd150 + {3'b0, glow_smoke[5:1]};
			end
			chc_pkg::MAT_LAVA: begin
				// Lava is colored by the animation path.
				rgb = '0;
			end
			default: begin
				rgb.red   = 8'hFF;
				rgb.green = 8'h00;
				rgb.blue  = 8'hFF;
			end
		endcase
	end

endmodule

### src/chc_lava.sv
module chc_lava (
	input  logic              clk,
	input  chc_pkg::lava_en_t en,
	input  chc_pkg::front_t   front,
	output chc_pkg::rgb_t     rgb
);

	// Stage 2: triangle waves as sign and magnitude around 127, amplitudes.
	logic [7:0]  fold_tri;
	logic [7:0]  pulse_tri;
	logic [6:0]  fmag_s2;
	logic        fneg_s2;
	logic [6:0]  pmag_s2;
	logic        pneg_s2;
	logic [5:0]  famp_s2;
	logic [4:0]  pamp_s2;
	logic [5:0]  heat_s2;

	// Stage 3: scaled wave products.
	logic [12:0] fprod_s3;
	logic        fneg_s3;
	logic [11:0] pprod_s3;
	logic        pneg_s3;
	logic [5:0]  heat_s3;

	// Stage 4: products divided by 127.
	logic [26:0] fq_full;
	logic [25:0] pq_full;
	logic [5:0]  fq_s4;
	logic        fneg_s4;
	logic [4:0]  pq_s4;
	logic        pneg_s4;
	logic [5:0]  heat_s4;

	logic [5:0]  f_up;
	logic [4:0]  f_dn;
	logic [3:0]  p_up;
	logic [5:0]  p_third;
	logic [5:0]  p_dn;
	logic [5:0]  p_blue;
	logic [6:0]  bright;
	logic [5:0]  dark;
	logic [8:0]  r_sum;
	logic [8:0]  g_sum;
	logic [8:0]  b_sum;

	assign fold_tri  = {front.fold_ph[7] ? ~front.fold_ph[6:0] : front.fold_ph[6:0], 1'b0};
	assign pulse_tri = {front.pulse_ph[7] ? ~front.pulse_ph[6:0] : front.pulse_ph[6:0],
		1'b0};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			fneg_s2 <= (fold_tri < 8'd127);
			fmag_s2 <= (fold_tri < 8'd127) ? 7'(8'd127 - fold_tri) : 7'(fold_tri - 8'd127);
			pneg_s2 <= (pulse_tri < 8'd127);
			pmag_s2 <= (pulse_tri < 8'd127) ? 7'(8'd127 - pulse_tri)
				: 7'(pulse_tri - 8'd127);
			famp_s2 <= 6'd8 + {1'b0, front.mob[5:1]} + {1'b0, front.strength, 2'b0};
			pamp_s2 <= 5'd4 + {1'b0, chc_pkg::div6_6(front.mob)}
				+ {1'b0, front.strength, 1'b0};
			heat_s2 <= front.heat;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			fprod_s3 <= {6'b0, fmag_s2} * {7'b0, famp_s2};
			fneg_s3  <= fneg_s2;
			pprod_s3 <= {5'b0, pmag_s2} * {7'b0, pamp_s2};
			pneg_s3  <= pneg_s2;
			heat_s3  <= heat_s2;
		end
	end

	// Truncating division keeps the sign apart, so the quotient of the
	// magnitude is the magnitude of the quotient.
	assign fq_full = {14'b0, fprod_s3} * {13'b0, chc_pkg::RECIP127};
	assign pq_full = {14'b0, pprod_s3} * {12'b0, chc_pkg::RECIP127};

	always_ff @(posedge clk) begin
		if (en.s4) begin
			fq_s4   <= fq_full[25:20];
			fneg_s4 <= fneg_s3;
			pq_s4   <= pq_full[24:20];
			pneg_s4 <= pneg_s3;
			heat_s4 <= heat_s3;
		end
	end

	// Positive wave halves brighten, negative halves darken.
	assign p_third = chc_pkg::div3_7({2'b0, pq_s4});
	assign f_up    = fneg_s4 ? 6'd0 : fq_s4;
	assign f_dn    = fneg_s4 ? fq_s4[5:1] : 5'd0;
	assign p_up    = pneg_s4 ? 4'd0 : pq_s4[4:1];
	assign p_dn    = pneg_s4 ? p_third : 6'd0;
	assign p_blue  = pneg_s4 ? 6'd0 : p_third;
	assign bright  = {1'b0, f_up} + {3'b0, p_up};
	assign dark    = {1'b0, f_dn} + p_dn;

	// Bright is at most 53 and dark at most 28, so red and green never
	// drop below zero; only the top needs clamping.
	assign r_sum = 9'd185 + {3'b0, heat_s4} + {2'b0, bright} - {4'b0, dark[5:1]};
	assign g_sum = 9'd50 + {4'b0, heat_s4[5:1]} + {3'b0, bright[6:1]}
		- {3'b0, chc_pkg::div3_7({1'b0, dark})};
	assign b_sum = 9'd12 + {3'b0, p_blue};

	assign rgb.red   = chc_pkg::sat8(r_sum);
	assign rgb.green = chc_pkg::sat8(g_sum);
	assign rgb.blue  = chc_pkg::sat8(b_sum);

endmodule

### src/cell_heat_colorizer.sv
// Colors one simulation cell per clock: each accepted transfer on grid gives exactly one
// opaque pixel (red, green, blue; alpha is implied 255) on pixel, in order. Static
// materials are tinted by a heat level taken from the temperature; lava is animated from
// frame_tick, the cell position and the flow inputs; invalid material codes give magenta.
// The block is a five-stage pipeline with a valid bit per stage, so a result leaves
// stage 5 when pixel is ready, and a new cell can be taken every cycle unless stalled.
// Stalls propagate stage by stage: an empty stage keeps accepting,
// so grid.ready only drops when all five stages hold a cell and pixel.ready is low.
// The depth is set by the lava path, which needs two multiplier stages (amplitude
// scaling, then division by 127 through a reciprocal). Only the low eight bits of
// pos_x, pos_y and frame_tick change the color; COORD_BITS (8 to 16) sets the width
// of the coordinate fields and must match the grid interface instance.
module cell_heat_colorizer #(
	parameter int COORD_BITS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	chc_cell_if.sink     grid,
	chc_pixel_if.source  pixel
);

	localparam int N = chc_pkg::STAGES;

	// vld_in[k] is the valid bit that stage k+1 loads; rdy[N+1] is the downstream ready.
	logic [N:1]   vld_q;
	logic [N-1:0] vld_in;
	logic [N+1:1] rdy;

	chc_pkg::front_t   front_s1;
	chc_pkg::rgb_t     tint_d;
	chc_pkg::rgb_t     lava_d;
	chc_pkg::lava_en_t lava_en;
	chc_pkg::rgb_t     tint_s2;
	chc_pkg::rgb_t     tint_s3;
	chc_pkg::rgb_t     tint_s4;
	logic              lava_s2;
	logic              lava_s3;
	logic              lava_s4;
	chc_pkg::rgb_t     rgb_s5;

	// A stage may load when it is empty or when its content moves on this cycle.
	always_comb begin
		rdy[N+1] = pixel.ready;
		for (int k = N; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign vld_in     = {vld_q[N-1:1], grid.valid};
	assign grid.ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= N; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_in[k-1];
				end
			end
		end
	end

	// Stage 1: heat level, mobility, flow strength and the two wave phases.
	chc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk           (clk),
		.en            (rdy[1]),
		.cell_type     (grid.cell_type),
		.temperature   (grid.temperature),
		.flow_direction(grid.flow_direction),
		.flow_level    (grid.flow_level),
		.pos_x         (grid.pos_x),
		.pos_y         (grid.pos_y),
		.frame_tick    (grid.frame_tick),
		.front_s1      (front_s1)
	);

	// Stage 2 input: the static material tint, which is then carried to the output.
	chc_tint u_tint (
		.cell_type(front_s1.cell_type),
		.heat     (front_s1.heat),
		.rgb      (tint_d)
	);

	// Stages 2 to 4: the lava animation; its color comes out after stage 4.
	assign lava_en.s2 = rdy[2];
	assign lava_en.s3 = rdy[3];
	assign lava_en.s4 = rdy[4];

	chc_lava u_lava (
		.clk  (clk),
		.en   (lava_en),
		.front(front_s1),
		.rgb  (lava_d)
	);

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			tint_s2 <= tint_d;
			lava_s2 <= front_s1.is_lava;
		end
		if (rdy[3]) begin
			tint_s3 <= tint_s2;
			lava_s3 <= lava_s2;
		end
		if (rdy[4]) begin
			tint_s4 <= tint_s3;
			lava_s4 <= lava_s3;
		end
		// Stage 5 is the output register; it holds while pixel stalls.
		if (rdy[5]) begin
			rgb_s5 <= lava_s4 ? lava_d : tint_s4;
		end
	end

	assign pixel.valid = vld_q[N];
	assign pixel.red   = rgb_s5.red;
	assign pixel.green = rgb_s5.green;
	assign pixel.blue  = rgb_s5.blue;

endmodule

### src/chc_checker.sv
`include "cell_heat_colorizer_defines.svh"

module chc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	localparam int OCC_W = $clog2(chc_pkg::STAGES + 1);
	localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(chc_pkg::STAGES);

	logic             in_fire;
	logic             out_fire;
	logic [OCC_W-1:0] occ_q;
	logic [23:0]      out_word;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign out_word = {out_red, out_green, out_blue};

	// Cells inside the block, counted from the port transfers alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_fire) - OCC_W'(out_fire);
		end
	end

	`CHC_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OCC_MAX)
	`CHC_ASSERT_NOW(a_no_phantom, out_valid, occ_q != '0)
	`CHC_ASSERT_NOW(a_full_stall, !in_ready, (occ_q == OCC_MAX) && !out_ready)
	`CHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind cell_heat_colorizer chc_checker u_chc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (grid.valid),
	.in_ready (grid.ready),
	.out_valid(pixel.valid),
	.out_ready(pixel.ready),
	.out_red  (pixel.red),
	.out_green(pixel.green),
	.out_blue (pixel.blue)
);
